FILE: rtl/core/bisc_pkg.sv
// ============================================================================
// bisc_pkg - shared types for the bitmap item support counter
// Word formats on both channels, controller/datapath command and status.
// ============================================================================
package bisc_pkg;

    localparam int WORD_BITS = 32;

    // input word
    typedef struct packed {
        logic        op;            // OP_ACCUM or OP_READ
        logic [4:0]  word_index;
        logic [31:0] mask_word;
        logic signed [31:0] weight;
        logic [9:0]  counter_index;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [9:0]  item_index;
        logic [31:0] count_value;
        logic        last;
    } t_out_word;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic clr;   // write zero at clear pointer, advance it
        logic load;  // capture input word, launch first counter read
        logic step;  // finish one result: update, emit, launch next read
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;  // clear pointer at final entry
        logic in_go;     // offered input word produces at least one result
        logic out_free;  // output register can take a word this cycle
        logic done;      // current step produces the final result
    } t_dp_stat;

    // index of lowest set bit (0 when none)
    function automatic logic [4:0] lsb_index(input logic [31:0] x);
        logic [31:0] oh;
        logic [4:0]  idx;
        oh  = x & (~x + 32'd1);
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (oh[i]) begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/core/bisc_ctrl.sv
// ============================================================================
// bisc_ctrl - sequencer for the support counter bank
// Runs the clear pass after reset, takes input words, steps through set bits.
// ============================================================================
module bisc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bisc_pkg::t_dp_stat i_stat,
    output bisc_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_UPD   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_go) begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/bisc_dp.sv
// ============================================================================
// bisc_dp - counter memory, bit scan, adder and output register
// One read and one write per cycle on the counter memory.
// ============================================================================
module bisc_dp #(
    parameter int MASK_WORDS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bisc_pkg::t_dp_cmd  i_cmd,
    output bisc_pkg::t_dp_stat o_stat,
    input  bisc_pkg::t_in_word i_in_word,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output bisc_pkg::t_out_word o_out_word
);

    localparam int NUM = MASK_WORDS * bisc_pkg::WORD_BITS;
    localparam int AW  = $clog2(NUM);
    localparam logic [11:0] NUM_W   = 12'(NUM);
    localparam logic [6:0]  WORDS_W = 7'(MASK_WORDS);

    logic [31:0] mem [NUM];

    logic        r_is_read;
    logic        r_in_range;
    logic [4:0]  r_word;
    logic [31:0] r_mask;
    logic [4:0]  r_bit;
    logic [9:0]  r_cidx;
    logic [31:0] r_weight;
    logic [31:0] r_rdata;
    logic [AW-1:0] r_clr_addr;
    logic        r_out_valid;
    bisc_pkg::t_out_word r_out;

    logic [31:0]   n_mask;
    logic [4:0]    n_bit;
    logic [4:0]    in_bit;
    logic          in_read_ok;
    logic          in_acc_ok;
    logic [31:0]   sum;
    logic          re;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    // input decode
    assign in_bit     = bisc_pkg::lsb_index(i_in_word.mask_word);
    assign in_read_ok = ({2'b00, i_in_word.counter_index} < NUM_W);
    assign in_acc_ok  = ({2'b00, i_in_word.word_index} < WORDS_W)
                      && (i_in_word.mask_word != 32'd0);

    // remaining bits after the current one
    assign n_mask = r_mask & (r_mask - 32'd1);
    assign n_bit  = bisc_pkg::lsb_index(n_mask);
    assign sum    = r_rdata + r_weight;

    assign o_stat.clr_last = (r_clr_addr == AW'(NUM - 1));
    assign o_stat.in_go    = (i_in_word.op == bisc_pkg::OP_READ) || in_acc_ok;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.done     = r_is_read || (n_mask == 32'd0);

    // memory port control
    always_comb begin
        re    = 1'b0;
        raddr = '0;
        if (i_cmd.load) begin
            if (i_in_word.op == bisc_pkg::OP_READ) begin
                re    = in_read_ok;
                raddr = AW'(i_in_word.counter_index);
            end else begin
                re    = in_acc_ok;
                raddr = AW'({i_in_word.word_index, in_bit});
            end
        end else if (i_cmd.step && !r_is_read) begin
            re    = (n_mask != 32'd0);
            raddr = AW'({r_word, n_bit});
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_clr_addr;
        wdata = '0;
        if (i_cmd.clr) begin
            we = 1'b1;
        end else if (i_cmd.step && !r_is_read) begin
            we    = 1'b1;
            waddr = AW'({r_word, r_bit});
            wdata = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_read  <= (i_in_word.op == bisc_pkg::OP_READ);
            r_in_range <= in_read_ok;
            r_word     <= i_in_word.word_index;
            r_mask     <= i_in_word.mask_word;
            r_bit      <= in_bit;
            r_cidx     <= i_in_word.counter_index;
            r_weight   <= i_in_word.weight;
        end else if (i_cmd.step) begin
            r_mask <= n_mask;
            r_bit  <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            if (r_is_read) begin
                r_out.item_index  <= r_cidx;
                r_out.count_value <= r_in_range ? r_rdata : 32'd0;
                r_out.last        <= 1'b1;
            end else begin
                r_out.item_index  <= {r_word, r_bit};
                r_out.count_value <= sum;
                r_out.last        <= (n_mask == 32'd0);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    // an accumulate step always works on a bit that is still set
    a_step_bit_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !r_is_read) |-> r_mask[r_bit])
        else $error("step on a cleared mask bit");

    // a result is never produced over an unaccepted one
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (!r_out_valid || !i_out_stall))
        else $error("output register overrun");

    // each accumulate step retires exactly one mask bit
    a_mask_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !r_is_read) |=>
            ($countones(r_mask) == $countones($past(r_mask)) - 1))
        else $error("mask did not lose one bit");

    // the clear pass and item work never overlap
    a_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |-> (!i_cmd.load && !i_cmd.step))
        else $error("clear pass overlaps item work");
`endif

endmodule

FILE: rtl/core/bitmap_item_support_counter.sv
// ============================================================================
// bitmap_item_support_counter - bank of per-item support counters
// Accumulates a signed weight into the counter of every set bit of a mask
// word, lowest bit first, and reads single counters back.
// ============================================================================
//
//  channel | valid       | stall        | word                  | direction
//  --------+-------------+--------------+-----------------------+----------
//  input   | i_in_valid  | o_in_stall   | i_in_word  (t_in_word) | in
//  output  | o_out_valid | i_out_stall  | o_out_word (t_out_word)| out
//
//  Cycles: an accumulate word takes 1 cycle to accept plus 1 cycle per set
//    mask bit (2..33); a read takes 2; a zero or out-of-range mask word takes 1.
//    The single counter memory port (one read, one write per cycle) sets this.
//  Reset: after i_rst_n the block runs a clear pass of MASK_WORDS*32 cycles
//    (1024 by default), one counter per cycle, with o_in_stall high.
//  Stalls: results sit in an output register; while it is held by i_out_stall
//    the block stops before the next counter update.
//  Counters wrap modulo 2^32. Reads beyond the bank return zero.
//
module bitmap_item_support_counter #(
    parameter int MASK_WORDS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bisc_pkg::t_in_word  i_in_word,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bisc_pkg::t_out_word o_out_word
);

    bisc_pkg::t_dp_cmd  cmd;
    bisc_pkg::t_dp_stat stat;

    // sequencer: clear pass, accept, one step per set bit
    bisc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // counter memory, bit scan, adder, output register
    bisc_dp #(
        .MASK_WORDS (MASK_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench - self-checking bench for bitmap_item_support_counter
// Words are queued by a stimulus thread, sent by a clocked driver and checked
// by a clocked monitor against a shadow copy of the support counter bank.
// ============================================================================
module testbench;

    localparam int MASK_WORDS   = 32;
    localparam int NUM_COUNTERS = MASK_WORDS * bisc_pkg::WORD_BITS;
    localparam int CYCLE_LIMIT  = 400000;  // clear pass + worst stall phases, many times over
    localparam int HOLD_CYCLES  = 600;     // long receiver hold-off
    localparam int QUIET_CYCLES = 40;      // settle time after the last result

    logic                i_clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    bisc_pkg::t_in_word  in_word   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    bisc_pkg::t_out_word out_word;

    // shadow of the counter bank and results still owed by the block
    logic [31:0]         counter_shadow [NUM_COUNTERS] = '{default: '0};
    bisc_pkg::t_out_word reports_due [$];
    bisc_pkg::t_in_word  words_to_send [$];

    int          send_gap_pct   = 0;   // chance per cycle the sender sits idle
    int          recv_stall_pct = 0;   // chance per cycle the receiver stalls
    logic        hold_go        = 1'b0;
    int          hold_left      = 0;
    int          fail_count     = 0;
    int unsigned cycle_count    = 0;

    bitmap_item_support_counter #(
        .MASK_WORDS (MASK_WORDS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shadow bank update for one accepted word; pushes the results it owes.
    // Accumulate walks set bits lowest first, last flag on the highest one.
    // ------------------------------------------------------------------------
    function automatic void apply_word(input bisc_pkg::t_in_word w);
        bisc_pkg::t_out_word r;
        logic [9:0]          idx;
        if (w.op == bisc_pkg::OP_READ) begin
            r.item_index  = w.counter_index;
            r.count_value = (int'(w.counter_index) < NUM_COUNTERS) ?
                            counter_shadow[w.counter_index] : 32'd0;
            r.last        = 1'b1;
            reports_due.push_back(r);
            return;
        end
        // zero word or word outside the bitmap: nothing happens
        if (int'(w.word_index) >= MASK_WORDS || w.mask_word == 32'd0) begin
            return;
        end
        for (int b = 0; b < bisc_pkg::WORD_BITS; b++) begin
            if (w.mask_word[b]) begin
                idx = 10'(int'(w.word_index) * bisc_pkg::WORD_BITS + b);
                // modulo 2^32; negative weight adds as its two's complement
                counter_shadow[idx] = counter_shadow[idx] + 32'(w.weight);
                r.item_index  = idx;
                r.count_value = counter_shadow[idx];
                r.last        = ((w.mask_word >> (b + 1)) == 32'd0);
                reports_due.push_back(r);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: holds a word until accepted, then offers the next one after a
    // random gap. Valid never drops while stalled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                apply_word(in_word);
            end
            if (!in_valid || !in_stall) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_valid <= 1'b1;
                    in_word  <= words_to_send.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here so the stimulus thread only kicks it
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                 $time, field, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: each accepted result word against the oldest owed one.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        bisc_pkg::t_out_word want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (reports_due.size() == 0) begin
                    note_mismatch("unexpected word, item_index", 32'd0,
                                  32'(out_word.item_index));
                end else begin
                    want = reports_due.pop_front();
                    if (out_word.item_index !== want.item_index) begin
                        note_mismatch("item_index", 32'(want.item_index),
                                      32'(out_word.item_index));
                    end
                    if (out_word.count_value !== want.count_value) begin
                        note_mismatch("count_value", want.count_value,
                                      out_word.count_value);
                    end
                    if (out_word.last !== want.last) begin
                        note_mismatch("last", 32'(want.last), 32'(out_word.last));
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_word(input logic op, input logic [4:0] widx,
                              input logic [31:0] mask, input logic [31:0] wt,
                              input logic [9:0] cidx);
        bisc_pkg::t_in_word w;
        w.op            = op;
        w.word_index    = widx;
        w.mask_word     = mask;
        w.weight        = wt;
        w.counter_index = cidx;
        words_to_send.push_back(w);
    endtask

    // sparse or zero masks half the time so stalled phases stay short, the rest full or random
    function automatic logic [31:0] pick_mask();
        logic [31:0] m;
        case ($urandom_range(9))
            0:       m = 32'd0;
            1:       m = '1;
            2, 3:    m = 32'd1 << $urandom_range(31);
            4, 5:    m = (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31))
                         | (32'd1 << $urandom_range(31));
            default: m = $urandom();
        endcase
        return m;
    endfunction

    function automatic logic [31:0] pick_weight();
        logic [31:0] v;
        case ($urandom_range(9))
            0:          v = 32'h7FFF_FFFF;
            1:          v = 32'h8000_0000;
            2:          v = 32'hFFFF_FFFF;
            3, 4, 5:    v = 32'($urandom_range(200)) - 32'd100;
            default:    v = $urandom();
        endcase
        return v;
    endfunction

    // accumulates mostly land on a few hot words so counts pile up and wrap;
    // half of the reads target a counter in the word they name
    task automatic queue_random(input int count);
        logic        op;
        logic [4:0]  widx;
        logic [9:0]  cidx;
        for (int k = 0; k < count; k++) begin
            op   = ($urandom_range(99) < 35) ? bisc_pkg::OP_READ : bisc_pkg::OP_ACCUM;
            widx = ($urandom_range(3) != 0) ? 5'($urandom_range(3)) : 5'($urandom());
            cidx = ($urandom_range(1) != 0) ? {widx, 5'($urandom())} : 10'($urandom());
            queue_word(op, widx, pick_mask(), pick_weight(), cidx);
        end
    endtask

    // sender idle until every owed result has come back
    task automatic wait_quiet();
        while (words_to_send.size() != 0 || in_valid || reports_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed: fresh counters, zero word, extremes, wrap, full word
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        queue_word(bisc_pkg::OP_READ,  5'd0,  32'd0,        32'd0,        10'd0);
        queue_word(bisc_pkg::OP_READ,  5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023);
        queue_word(bisc_pkg::OP_ACCUM, 5'd0,  32'd0,        32'd5,        10'd0);
        queue_word(bisc_pkg::OP_ACCUM, 5'd0,  32'd1,        32'd1,        10'd1023);
        queue_word(bisc_pkg::OP_ACCUM, 5'd31, 32'h8000_0000, 32'h7FFF_FFFF, 10'd0);
        queue_word(bisc_pkg::OP_ACCUM, 5'd31, 32'h8000_0000, 32'd1,        10'd0);
        queue_word(bisc_pkg::OP_ACCUM, 5'd31, 32'h8000_0000, 32'h8000_0000, 10'd0);
        queue_word(bisc_pkg::OP_READ,  5'd0,  32'd0,        32'd0,        10'd1023);
        queue_word(bisc_pkg::OP_ACCUM, 5'd5,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0);
        queue_word(bisc_pkg::OP_ACCUM, 5'd5,  32'hFFFF_FFFF, 32'd1,        10'd0);
        queue_word(bisc_pkg::OP_ACCUM, 5'd5,  32'hAAAA_AAAA, 32'h8000_0000, 10'd0);
        queue_word(bisc_pkg::OP_ACCUM, 5'd5,  32'h5555_5555, 32'h7FFF_FFFF, 10'd0);
        queue_word(bisc_pkg::OP_READ,  5'd0,  32'd0,        32'd0,        10'd161);
        queue_word(bisc_pkg::OP_READ,  5'd0,  32'd0,        32'd0,        10'd160);
        queue_word(bisc_pkg::OP_ACCUM, 5'd17, 32'd0,        32'hFFFF_FFFF, 10'd511);
        queue_word(bisc_pkg::OP_ACCUM, 5'd16, 32'h0001_8000, 32'hFFFF_FFFE, 10'd512);
        queue_word(bisc_pkg::OP_READ,  5'd10, 32'h1234_5678, 32'h8765_4321, 10'd527);
        queue_word(bisc_pkg::OP_READ,  5'd0,  32'd0,        32'd0,        10'd0);
        queue_word(bisc_pkg::OP_READ,  5'd0,  32'd0,        32'd0,        10'd512);
        wait_quiet();

        // no idling
        queue_random(90);
        wait_quiet();

        // sparse sender
        send_gap_pct = 77;
        queue_random(70);
        wait_quiet();

        // slow receiver
        send_gap_pct   = 0;
        recv_stall_pct = 77;
        queue_random(70);
        wait_quiet();

        // light idling on both sides
        send_gap_pct   = 6;
        recv_stall_pct = 6;
        queue_random(80);
        wait_quiet();

        // receiver holds off while the sender keeps offering: input backs up
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        queue_word(bisc_pkg::OP_ACCUM, 5'd2, 32'hFFFF_FFFF, 32'd3, 10'd0);
        queue_random(40);
        wait_quiet();

        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
